FILE: rtl/grpm_pkg.sv
`timescale 1ns / 1ps
package grpm_pkg;

  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 16;
  localparam int GAINED_W = 28;
  localparam int DB_W     = 16;
  localparam int SUM_W    = 56;
  localparam int PEAK_W   = 27;
  localparam int CNT_W    = 16;
  localparam int DIVR_W   = CNT_W + 1;
  localparam int ROOT_W   = 32;
  localparam int LOGY_W   = 31;
  localparam int FRAC_W   = 16;
  localparam int LOGN_W   = 5;
  localparam int LEVEL_W  = 33;
  localparam int STEP_W   = 6;

  localparam int DIV_STEPS  = SUM_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int LOG_STEPS  = FRAC_W;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;
  localparam logic [CNT_W-1:0]  WIN_RESET  = 16'd4800;
  localparam logic [LEVEL_W-1:0] EPS_UNITS = 33'd17;
  localparam logic signed [19:0] DB_K      = 20'sd394566;
  localparam logic signed [17:0] DB_FLOOR  = -18'sd30720;
  localparam logic signed [17:0] DB_CEIL   = 18'sd6400;

  localparam logic CFG_GAIN   = 1'b0;
  localparam logic CFG_WINDOW = 1'b1;

  typedef struct packed {
    logic ld_in;
    logic mul;
    logic sat;
    logic sq;
    logic acc;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic nrm_init;
    logic nrm_step;
    logic log_step;
    logic db_mul;
    logic db_store;
    logic out_load;
    logic sel;
  } grpm_cmd_t;

  typedef struct packed {
    logic publish;
    logic norm_done;
    logic out_free;
  } grpm_stat_t;

endpackage

FILE: rtl/grpm_ctrl.sv
`timescale 1ns / 1ps
module grpm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  grpm_pkg::grpm_stat_t stat,
  output grpm_pkg::grpm_cmd_t  cmd
);
  import grpm_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE = 14'(1 << 0),
    S_MUL  = 14'(1 << 1),
    S_SAT  = 14'(1 << 2),
    S_SQ   = 14'(1 << 3),
    S_ACC  = 14'(1 << 4),
    S_DIV  = 14'(1 << 5),
    S_SQI  = 14'(1 << 6),
    S_SQRT = 14'(1 << 7),
    S_NRMI = 14'(1 << 8),
    S_NORM = 14'(1 << 9),
    S_LOG  = 14'(1 << 10),
    S_DBM  = 14'(1 << 11),
    S_DBC  = 14'(1 << 12),
    S_OUT  = 14'(1 << 13)
  } state_t;

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   cnt_r, cnt_nxt;
  logic                sel_r, sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      sel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sel_nxt   = sel_r;
    in_tready = 1'b0;
    cmd       = '0;
    cmd.sel   = sel_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.ld_in = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SAT;
      end
      S_SAT: begin
        cmd.sat   = 1'b1;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (stat.publish) begin
          state_nxt = S_DIV;
          cnt_nxt   = STEP_W'(DIV_STEPS - 1);
          sel_nxt   = 1'b0;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) state_nxt = S_SQI;
        else cnt_nxt = cnt_r - 1'b1;
      end
      S_SQI: begin
        cmd.sqrt_init = 1'b1;
        cnt_nxt       = STEP_W'(SQRT_STEPS - 1);
        state_nxt     = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt_r == '0) state_nxt = S_NRMI;
        else cnt_nxt = cnt_r - 1'b1;
      end
      S_NRMI: begin
        cmd.nrm_init = 1'b1;
        state_nxt    = S_NORM;
      end
      S_NORM: begin
        if (stat.norm_done) begin
          state_nxt = S_LOG;
          cnt_nxt   = STEP_W'(LOG_STEPS - 1);
        end else begin
          cmd.nrm_step = 1'b1;
        end
      end
      S_LOG: begin
        cmd.log_step = 1'b1;
        if (cnt_r == '0) state_nxt = S_DBM;
        else cnt_nxt = cnt_r - 1'b1;
      end
      S_DBM: begin
        cmd.db_mul = 1'b1;
        state_nxt  = S_DBC;
      end
      S_DBC: begin
        cmd.db_store = 1'b1;
        if (!sel_r) begin
          sel_nxt   = 1'b1;
          state_nxt = S_NRMI;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/grpm_dp.sv
`timescale 1ns / 1ps
module grpm_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic                               cfg_addr,
  input  logic [grpm_pkg::GAIN_W-1:0]        cfg_wdata,
  input  logic [grpm_pkg::SAMPLE_W-1:0]      sample_in,
  input  grpm_pkg::grpm_cmd_t                cmd,
  output grpm_pkg::grpm_stat_t               stat,
  input  logic                               out_tready,
  output logic                               out_valid,
  output logic signed [grpm_pkg::GAINED_W-1:0] gained_sample,
  output logic                               meter_valid,
  output logic signed [grpm_pkg::DB_W-1:0]   rms_db,
  output logic signed [grpm_pkg::DB_W-1:0]   peak_db
);
  import grpm_pkg::*;

  logic [GAIN_W-1:0]         gain_r;
  logic [CNT_W-1:0]          win_r;
  logic signed [SAMPLE_W-1:0] samp_r;
  logic signed [SAMPLE_W+GAIN_W:0] prod_r;
  logic signed [GAINED_W-1:0] q_r;
  logic [GAINED_W-1:0]       aq_r;
  logic [2*GAINED_W-15:0]    sq_r;
  logic [SUM_W-1:0]          sum_r;
  logic [PEAK_W-1:0]         peak_r, peak_hold_r;
  logic [CNT_W-1:0]          count_r;
  logic                      meter_r;
  logic [SUM_W-1:0]          quo_r;
  logic [DIVR_W-1:0]         rem_r, divisor_r;
  logic [63:0]               v_r;
  logic [ROOT_W+1:0]         srem_r;
  logic [ROOT_W-1:0]         root_r;
  logic [LOGY_W-1:0]         y_r;
  logic [LOGN_W-1:0]         n_r;
  logic                      ovf_r;
  logic [FRAC_W-1:0]         frac_r;
  logic signed [41:0]        dbp_r;
  logic signed [DB_W-1:0]    rms_r, pk_r;
  logic                      out_valid_r;
  logic signed [GAINED_W-1:0] out_g_r;
  logic                      out_m_r;
  logic signed [DB_W-1:0]    out_rms_r, out_pk_r;

  // gain and saturation
  logic signed [SAMPLE_W+GAIN_W+1:0] rnd;
  logic signed [GAINED_W:0]  q29;
  logic signed [GAINED_W-1:0] q_sat;
  assign rnd = {prod_r[SAMPLE_W+GAIN_W], prod_r} + 42'sd2048;
  assign q29 = rnd[GAINED_W+12:12];
  always_comb begin
    if (q29 > $signed({2'b00, {(GAINED_W-1){1'b1}}}))
      q_sat = {1'b0, {(GAINED_W-1){1'b1}}};
    else if (q29 < $signed({2'b11, {(GAINED_W-1){1'b0}}}))
      q_sat = {1'b1, {(GAINED_W-1){1'b0}}};
    else
      q_sat = q29[GAINED_W-1:0];
  end

  // square at full width
  logic [2*GAINED_W-1:0] aq_sq;
  assign aq_sq = aq_r * aq_r;

  // accumulate
  logic [SUM_W:0]   sum_add;
  logic [SUM_W-1:0] sum_nxt;
  logic [PEAK_W-1:0] peak_nxt;
  logic [CNT_W-1:0] count_nxt;
  assign sum_add   = {1'b0, sum_r} + (SUM_W+1)'(sq_r);
  assign sum_nxt   = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
  assign count_nxt = count_r + 1'b1;
  always_comb begin
    peak_nxt = peak_r;
    if (aq_r > {1'b0, peak_r})
      peak_nxt = aq_r[GAINED_W-1] ? {PEAK_W{1'b1}} : aq_r[PEAK_W-1:0];
  end

  // divide step
  logic [DIVR_W:0] r2;
  logic            dge;
  assign r2  = {rem_r, quo_r[SUM_W-1]};
  assign dge = r2 >= {1'b0, divisor_r};

  // root step
  logic [ROOT_W+3:0] r4, trial;
  logic              sge;
  assign r4    = {srem_r, v_r[63:62]};
  assign trial = {2'b00, root_r, 2'b01};
  assign sge   = r4 >= trial;

  // level and normalisation
  logic [LEVEL_W-1:0] lvl;
  assign lvl = cmd.sel ? (LEVEL_W'({peak_hold_r, 1'b0}) + EPS_UNITS)
                       : (LEVEL_W'(root_r) + EPS_UNITS);

  // log squaring
  logic [2*LOGY_W-1:0] ysq;
  logic [31:0]         ysh;
  assign ysq = y_r * y_r;
  assign ysh = ysq[61:30];

  // dB scaling
  logic signed [21:0] dlog;
  logic signed [41:0] dbt;
  logic signed [17:0] db18;
  logic signed [DB_W-1:0] db_cl;
  assign dlog = $signed({1'b0, n_r, frac_r}) - 22'sd1572864;
  assign dbt  = dbp_r + 42'sd8388608;
  assign db18 = dbt[41:24];
  always_comb begin
    if (db18 < DB_FLOOR) db_cl = DB_W'(DB_FLOOR);
    else if (db18 > DB_CEIL) db_cl = DB_W'(DB_CEIL);
    else db_cl = db18[DB_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= GAIN_RESET;
      win_r       <= WIN_RESET;
      sum_r       <= '0;
      peak_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_GAIN) gain_r <= cfg_wdata;
        else win_r <= cfg_wdata;
      end
      if (cmd.acc) begin
        if (stat.publish) begin
          sum_r   <= '0;
          peak_r  <= '0;
          count_r <= '0;
        end else begin
          sum_r   <= sum_nxt;
          peak_r  <= peak_nxt;
          count_r <= count_nxt;
        end
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) samp_r <= sample_in;
    if (cmd.mul) prod_r <= samp_r * $signed({1'b0, gain_r});
    if (cmd.sat) begin
      q_r  <= q_sat;
      aq_r <= q_sat[GAINED_W-1] ? GAINED_W'(-q_sat) : q_sat;
    end
    if (cmd.sq) sq_r <= aq_sq[2*GAINED_W-1:14];
    if (cmd.acc) begin
      meter_r     <= stat.publish;
      quo_r       <= sum_nxt;
      rem_r       <= '0;
      divisor_r   <= (count_nxt == '0) ? {1'b1, {CNT_W{1'b0}}} : {1'b0, count_nxt};
      peak_hold_r <= peak_nxt;
    end
    if (cmd.div_step) begin
      rem_r <= dge ? DIVR_W'(r2 - {1'b0, divisor_r}) : r2[DIVR_W-1:0];
      quo_r <= {quo_r[SUM_W-2:0], dge};
    end
    if (cmd.sqrt_init) begin
      v_r    <= {quo_r[47:0], 16'd0};
      srem_r <= '0;
      root_r <= '0;
    end
    if (cmd.sqrt_step) begin
      srem_r <= sge ? (ROOT_W+2)'(r4 - trial) : r4[ROOT_W+1:0];
      root_r <= {root_r[ROOT_W-2:0], sge};
      v_r    <= {v_r[61:0], 2'b00};
    end
    if (cmd.nrm_init) begin
      y_r    <= lvl[LOGY_W-1:0];
      n_r    <= LOGN_W'(30);
      ovf_r  <= lvl[LEVEL_W-1] | lvl[LEVEL_W-2];
      frac_r <= '0;
    end
    if (cmd.nrm_step) begin
      y_r <= {y_r[LOGY_W-2:0], 1'b0};
      n_r <= n_r - 1'b1;
    end
    if (cmd.log_step) begin
      y_r    <= ysh[31] ? ysh[31:1] : ysh[30:0];
      frac_r <= {frac_r[FRAC_W-2:0], ysh[31]};
    end
    if (cmd.db_mul) dbp_r <= dlog * DB_K;
    if (cmd.db_store) begin
      if (cmd.sel) pk_r <= db_cl;
      else rms_r <= db_cl;
    end
    if (cmd.out_load) begin
      out_g_r   <= q_r;
      out_m_r   <= meter_r;
      out_rms_r <= meter_r ? rms_r : '0;
      out_pk_r  <= meter_r ? pk_r : '0;
    end
  end

  assign stat.publish   = (count_nxt >= win_r) || (count_nxt == '0);
  assign stat.norm_done = y_r[LOGY_W-1] | ovf_r;
  assign stat.out_free  = !out_valid_r || out_tready;

  assign out_valid     = out_valid_r;
  assign gained_sample = out_g_r;
  assign meter_valid   = out_m_r;
  assign rms_db        = out_rms_r;
  assign peak_db       = out_pk_r;

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc && stat.publish |=> count_r == '0 && sum_r == '0 && peak_r == '0)
    else $error("accumulators not cleared after publish");
  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load && !meter_r |=> rms_db == '0 && peak_db == '0 && !meter_valid)
    else $error("meter fields set on a quiet beat");
  a_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_valid_r || out_tready)
    else $error("output beat overwritten");

endmodule

FILE: rtl/gain_and_rms_peak_meter_unit.sv
`timescale 1ns / 1ps
// With no meter value due, a beat passes multiply, saturate, square and
// accumulate to output. A publishing beat adds a bit-serial divide, a root
// and two dB conversions (RMS, then peak), each a normalising shift and
// 16 log squarings. One sample in flight: a new one waits for the output load.
// rst_n synchronous: gain 1.0, window 4800, accumulators and output valid cleared.
module gain_and_rms_peak_meter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // sample_in[23:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // gained_sample[27:0], rms_db[43:28], peak_db[59:44]
  output logic        out_tuser   // meter_valid
);
  import grpm_pkg::*;

  grpm_cmd_t  cmd;
  grpm_stat_t stat;
  logic signed [GAINED_W-1:0] gained;
  logic signed [DB_W-1:0]     rms, pk;

  grpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  grpm_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .sample_in     (in_tdata),
    .cmd           (cmd),
    .stat          (stat),
    .out_tready    (out_tready),
    .out_valid     (out_tvalid),
    .gained_sample (gained),
    .meter_valid   (out_tuser),
    .rms_db        (rms),
    .peak_db       (pk)
  );

  assign out_tdata = {4'b0000, pk, rms, gained};

endmodule
